### rtl/vmt_pkg.sv
// ============================================================================
// vmt_pkg: shared types, constants and helpers
// Fixed-point format, matrix type and rounding helpers for the MVP transform.
// ============================================================================
package vmt_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_ITERS = 16;

    localparam int ATAN_LEN = 24;
    localparam int N_IT     = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
    localparam int IT_W     = $clog2(N_IT);
    localparam int SHIFT    = 30 - FRAC_BITS;          // Q16 -> Q30
    localparam int RED_M    = SHIFT - 1;               // top step of the 2pi reduction
    localparam int J_W      = $clog2(RED_M + 1);
    localparam int RED_W    = SHIFT + 36;

    localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;

    localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] NEG_ONE = -ONE;
    localparam logic signed [31:0] W_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] W_MIN   = 32'sh8000_0000;

    localparam int N_CFG  = 4;
    localparam int CIDX_W = 8;
    localparam logic [CIDX_W-1:0] CFG_X_SCALE  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_Y_SCALE  = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_Z_SCALE  = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] CFG_Z_OFFSET = CIDX_W'(3);

    localparam logic OP_INSTANCE = 1'b0;
    localparam logic OP_VERTEX   = 1'b1;

    typedef logic signed [31:0] t_word;
    typedef logic [15:0][31:0]  t_mat;       // row-major, entry i = row*4+col
    typedef logic signed [33:0] t_acc;

    typedef enum logic [2:0] {
        S_IDLE, S_TRIG_X, S_TRIG_Y, S_LOAD, S_RUN, S_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        C_IDLE, C_RED, C_FOLD, C_ITER, C_DONE
    } t_cstate;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_lane_ctl;

    typedef struct packed {
        logic  done;
        t_word sin_v;
        t_word cos_v;
    } t_trig;

    function automatic t_mat f_ident();
        t_mat m;
        m = '0;
        m[0]  = ONE;
        m[5]  = ONE;
        m[10] = ONE;
        m[15] = ONE;
        return m;
    endfunction

    // round half up, floor shift, saturate
    function automatic t_word f_qround(input logic signed [63:0] p);
        logic signed [64:0] s;
        logic signed [64:0] sh;
        s  = {p[63], p} + (65'sd1 <<< (FRAC_BITS - 1));
        sh = s >>> FRAC_BITS;
        if (sh > 65'(W_MAX))      return W_MAX;
        else if (sh < 65'(W_MIN)) return W_MIN;
        else                      return sh[31:0];
    endfunction

    function automatic t_word f_sat34(input t_acc v);
        if (v > 34'(W_MAX))      return W_MAX;
        else if (v < 34'(W_MIN)) return W_MIN;
        else                     return v[31:0];
    endfunction

    function automatic logic signed [35:0] f_atan(input logic [IT_W-1:0] i);
        logic signed [35:0] v;
        case (5'(i))
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            5'd11:   v = 36'sd524288;
            5'd12:   v = 36'sd262144;
            5'd13:   v = 36'sd131072;
            5'd14:   v = 36'sd65536;
            5'd15:   v = 36'sd32768;
            5'd16:   v = 36'sd16384;
            5'd17:   v = 36'sd8192;
            5'd18:   v = 36'sd4096;
            5'd19:   v = 36'sd2048;
            5'd20:   v = 36'sd1024;
            5'd21:   v = 36'sd512;
            5'd22:   v = 36'sd256;
            5'd23:   v = 36'sd128;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/vertex_mvp_transform_unit.sv
// ============================================================================
// vertex_mvp_transform_unit: fixed-point MVP vertex transform
// Builds P*T*RX*RY*S on instance transactions, applies it to vertices.
// ============================================================================
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_ready      | opcode, pos, color, inst
//  out      | output    | o_out_valid / i_out_ready    | clip_x..clip_w, color_out
//  cfg      | input     | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
//  Between the accept of a vertex transaction and the next accept lie the
//  accept cycle, the issue cycles through the row lanes and the drain
//  cycles of the lane pipeline.
//  An instance transaction runs two CORDIC passes (reduction, fold and
//  iterations each) and four 4x4 products.
//  Reset (synchronous, active low) restores the projection registers and sets
//  the stored matrix to identity. A finished vertex waits in the output
//  register; the next transaction is still taken, and only its own delivery
//  stalls while the output is held.
// ============================================================================
module vertex_mvp_transform_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_pos_w,
    input  logic [63:0] i_color_rgba,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    input  logic signed [31:0] i_offset_z,
    input  logic signed [31:0] i_angle_x,
    input  logic signed [31:0] i_angle_y,
    input  logic signed [31:0] i_scale_factor,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_clip_x,
    output logic signed [31:0] o_clip_y,
    output logic signed [31:0] o_clip_z,
    output logic signed [31:0] o_clip_w,
    output logic [63:0] o_color_out
);
    // configuration (projection entries)
    vmt_pkg::t_word r_cfg [vmt_pkg::N_CFG];

    // control
    vmt_pkg::t_state r_state, n_state;
    logic       r_vtx;
    logic [1:0] r_phase, r_k, r_c, r_c_last, r_drain;
    vmt_pkg::t_mat r_mvp;

    // operand matrices; lanes always tap A[row][0] and B[0][0], and both
    // matrices rotate so every k and column step reaches those taps
    vmt_pkg::t_mat r_a, r_b;

    // latched instance data
    vmt_pkg::t_word r_off_x, r_off_y, r_off_z, r_scale, r_ang_y;
    vmt_pkg::t_word r_cx, r_sx, r_cy, r_sy;
    logic [63:0]    r_color;

    // output register
    logic           r_out_valid;
    vmt_pkg::t_word r_clip [4];
    logic [63:0]    r_color_out;

    // datapath links
    vmt_pkg::t_lane_ctl lane_ctl;
    logic               lane_done [4];
    vmt_pkg::t_acc      lane_acc  [4];
    vmt_pkg::t_mat      res;
    vmt_pkg::t_trig     trig;
    logic               trig_start;
    vmt_pkg::t_word     trig_angle;

    logic in_acc, out_free, fin;
    vmt_pkg::t_mat m_t, m_rx, m_ry, m_s, m_p, ld_a, ld_b, vb;

    assign o_in_ready = (r_state == vmt_pkg::S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign fin        = (r_state == vmt_pkg::S_DRAIN) && (r_drain == 2'd2);

    // ---- config writes; out-of-range indexes fall through ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 32'sd63843;
            r_cfg[1] <= 32'sd113512;
            r_cfg[2] <= -32'sd65580;
            r_cfg[3] <= -32'sd13112;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vmt_pkg::CFG_X_SCALE:  r_cfg[0] <= i_cfg_data;
                vmt_pkg::CFG_Y_SCALE:  r_cfg[1] <= i_cfg_data;
                vmt_pkg::CFG_Z_SCALE:  r_cfg[2] <= i_cfg_data;
                vmt_pkg::CFG_Z_OFFSET: r_cfg[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- operand matrices for each product of the chain ----
    always_comb begin
        m_t = vmt_pkg::f_ident();
        m_t[3]  = r_off_x;
        m_t[7]  = r_off_y;
        m_t[11] = r_off_z;
        m_rx = vmt_pkg::f_ident();
        m_rx[5]  = r_cx;
        m_rx[6]  = -r_sx;
        m_rx[9]  = r_sx;
        m_rx[10] = r_cx;
        m_ry = vmt_pkg::f_ident();
        m_ry[0]  = r_cy;
        m_ry[2]  = r_sy;
        m_ry[8]  = -r_sy;
        m_ry[10] = r_cy;
        m_s = vmt_pkg::f_ident();
        m_s[0]  = r_scale;
        m_s[5]  = r_scale;
        m_s[10] = r_scale;
        m_p = '0;
        m_p[0]  = r_cfg[0];
        m_p[5]  = r_cfg[1];
        m_p[10] = r_cfg[2];
        m_p[11] = r_cfg[3];
        m_p[14] = vmt_pkg::NEG_ONE;
        // phase 0: T*RX, 1: R*RY, 2: R*S, 3: P*R
        case (r_phase)
            2'd0:    begin ld_a = m_t; ld_b = m_rx; end
            2'd1:    begin ld_a = res; ld_b = m_ry; end
            2'd2:    begin ld_a = res; ld_b = m_s;  end
            default: begin ld_a = m_p; ld_b = res;  end
        endcase
        // vertex as column 0 of B
        vb = '0;
        vb[0]  = i_pos_x;
        vb[4]  = i_pos_y;
        vb[8]  = i_pos_z;
        vb[12] = i_pos_w;
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vmt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_opcode == vmt_pkg::OP_VERTEX) ? vmt_pkg::S_RUN
                                                               : vmt_pkg::S_TRIG_X;
                end
            end
            vmt_pkg::S_TRIG_X: if (trig.done) n_state = vmt_pkg::S_TRIG_Y;
            vmt_pkg::S_TRIG_Y: if (trig.done) n_state = vmt_pkg::S_LOAD;
            vmt_pkg::S_LOAD:   n_state = vmt_pkg::S_RUN;
            vmt_pkg::S_RUN: begin
                if (r_k == 2'd3 && r_c == r_c_last) n_state = vmt_pkg::S_DRAIN;
            end
            vmt_pkg::S_DRAIN: begin
                if (fin) begin
                    if (r_vtx) begin
                        if (out_free) n_state = vmt_pkg::S_IDLE;
                    end else begin
                        n_state = (r_phase == 2'd3) ? vmt_pkg::S_IDLE : vmt_pkg::S_LOAD;
                    end
                end
            end
            default: n_state = vmt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vmt_pkg::S_IDLE;
            r_mvp   <= vmt_pkg::f_ident();
            r_vtx   <= 1'b0;
            r_phase <= '0;
            r_k     <= '0;
            r_c     <= '0;
            r_c_last <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_vtx    <= (i_opcode == vmt_pkg::OP_VERTEX);
                r_phase  <= '0;
                r_k      <= '0;
                r_c      <= '0;
                r_c_last <= '0;
            end
            if (r_state == vmt_pkg::S_LOAD) begin
                r_k      <= '0;
                r_c      <= '0;
                r_c_last <= 2'd3;
            end
            if (r_state == vmt_pkg::S_RUN) begin
                r_k     <= r_k + 1'b1;
                r_drain <= '0;
                if (r_k == 2'd3) r_c <= r_c + 1'b1;
            end
            if (r_state == vmt_pkg::S_DRAIN && !fin) r_drain <= r_drain + 1'b1;
            if (fin && !r_vtx) begin
                if (r_phase == 2'd3) r_mvp <= res;
                r_phase <= r_phase + 1'b1;
            end
        end
    end

    // ---- operand rotation and instance latches ----
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a     <= r_mvp;
            r_b     <= vb;
            r_color <= i_color_rgba;
            r_off_x <= i_offset_x;
            r_off_y <= i_offset_y;
            r_off_z <= i_offset_z;
            r_scale <= i_scale_factor;
            r_ang_y <= i_angle_y;
        end
        if (r_state == vmt_pkg::S_TRIG_X && trig.done) begin
            r_cx <= trig.cos_v;
            r_sx <= trig.sin_v;
        end
        if (r_state == vmt_pkg::S_TRIG_Y && trig.done) begin
            r_cy <= trig.cos_v;
            r_sy <= trig.sin_v;
        end
        if (r_state == vmt_pkg::S_LOAD) begin
            r_a <= ld_a;
            r_b <= ld_b;
        end
        if (r_state == vmt_pkg::S_RUN) begin
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 4; j++) begin
                    // A rows rotate left one entry per k step
                    r_a[r*4+j] <= r_a[r*4+((j+1)%4)];
                    // B rows rotate up per k step; after the fourth step
                    // the columns also rotate left to bring the next column
                    if (r_k == 2'd3) begin
                        r_b[r*4+j] <= r_b[((r+1)%4)*4+((j+1)%4)];
                    end else begin
                        r_b[r*4+j] <= r_b[((r+1)%4)*4+j];
                    end
                end
            end
        end
    end

    // ---- lanes: one per result row ----
    always_comb begin
        lane_ctl.valid = (r_state == vmt_pkg::S_RUN);
        lane_ctl.first = (r_k == 2'd0);
        lane_ctl.last  = (r_k == 2'd3);
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        vmt_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_a     (r_a[g*4]),
            .i_b     (r_b[0]),
            .o_done  (lane_done[g]),
            .o_acc   (lane_acc[g])
        );
    end

    vmt_merge u_merge (
        .i_clk  (i_clk),
        .i_done (lane_done[0]),
        .i_acc0 (lane_acc[0]),
        .i_acc1 (lane_acc[1]),
        .i_acc2 (lane_acc[2]),
        .i_acc3 (lane_acc[3]),
        .o_res  (res)
    );

    // ---- sine/cosine unit, angle X then angle Y ----
    assign trig_start = (in_acc && i_opcode == vmt_pkg::OP_INSTANCE) ||
                        (r_state == vmt_pkg::S_TRIG_X && trig.done);
    assign trig_angle = (r_state == vmt_pkg::S_IDLE) ? i_angle_x : r_ang_y;

    vmt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (trig_angle),
        .o_trig  (trig)
    );

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin && r_vtx && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (fin && r_vtx && out_free) begin
            for (int r = 0; r < 4; r++) r_clip[r] <= res[r*4+3];
            r_color_out <= r_color;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clip_x    = r_clip[0];
    assign o_clip_y    = r_clip[1];
    assign o_clip_z    = r_clip[2];
    assign o_clip_w    = r_clip[3];
    assign o_color_out = r_color_out;

    // ---- assertions ----
    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !lane_ctl.valid)
        else $error("lane issue while accepting");

    // earlier columns of a 4x4 product finish while later ones still issue
    a_merge_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done[0] |-> (r_state == vmt_pkg::S_RUN || r_state == vmt_pkg::S_DRAIN))
        else $error("lane result outside run or drain");

    a_trig_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig.done |-> (r_state == vmt_pkg::S_TRIG_X || r_state == vmt_pkg::S_TRIG_Y))
        else $error("trig result outside trig states");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vtx))
        else $error("output from instance transaction");
endmodule

### rtl/vmt_lane.sv
// ============================================================================
// vmt_lane: one multiply-accumulate lane
// Registered 32x32 product, then round/saturate and a 4-term accumulate.
// ============================================================================
module vmt_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vmt_pkg::t_lane_ctl i_ctl,
    input  vmt_pkg::t_word     i_a,
    input  vmt_pkg::t_word     i_b,
    output logic               o_done,
    output vmt_pkg::t_acc      o_acc
);
    logic signed [63:0] r_prod;
    vmt_pkg::t_lane_ctl r_ctl;
    vmt_pkg::t_acc      r_acc;
    logic               r_done;
    vmt_pkg::t_acc      n_acc;
    vmt_pkg::t_word     q;

    always_comb begin
        q     = vmt_pkg::f_qround(r_prod);
        n_acc = r_ctl.first ? 34'(q) : r_acc + 34'(q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid & r_ctl.last;
        end
        r_prod <= $signed(i_a) * $signed(i_b);
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

### rtl/vmt_merge.sv
// ============================================================================
// vmt_merge: result assembly
// Saturates the four lane sums and shifts them in as one result column.
// ============================================================================
module vmt_merge (
    input  logic             i_clk,
    input  logic             i_done,
    input  vmt_pkg::t_acc    i_acc0,
    input  vmt_pkg::t_acc    i_acc1,
    input  vmt_pkg::t_acc    i_acc2,
    input  vmt_pkg::t_acc    i_acc3,
    output vmt_pkg::t_mat    o_res
);
    vmt_pkg::t_mat  r_res;
    vmt_pkg::t_word col [4];

    always_comb begin
        col[0] = vmt_pkg::f_sat34(i_acc0);
        col[1] = vmt_pkg::f_sat34(i_acc1);
        col[2] = vmt_pkg::f_sat34(i_acc2);
        col[3] = vmt_pkg::f_sat34(i_acc3);
    end

    // columns arrive in order; newest goes to column 3
    always_ff @(posedge i_clk) begin
        if (i_done) begin
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_res[r*4+j] <= r_res[r*4+j+1];
                end
                r_res[r*4+3] <= col[r];
            end
        end
    end

    assign o_res = r_res;
endmodule

### rtl/vmt_cordic.sv
// ============================================================================
// vmt_cordic: iterative sine/cosine
// 2pi reduction one step a cycle, quadrant fold, then one CORDIC step a cycle.
// ============================================================================
module vmt_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  vmt_pkg::t_word i_angle,
    output vmt_pkg::t_trig o_trig
);
    localparam int RED_W = vmt_pkg::RED_W;
    localparam logic [RED_W-1:0] TWO_PI_W = RED_W'(vmt_pkg::TWO_PI_Q30);

    vmt_pkg::t_cstate       r_st, n_st;
    logic [RED_W-1:0]       r_u;
    logic [vmt_pkg::J_W-1:0]  r_j;
    logic [vmt_pkg::IT_W-1:0] r_i;
    logic signed [35:0]     r_x, r_y, r_z;
    logic                   r_neg;

    logic [RED_W-1:0]       ang_ext, cmp;
    logic signed [35:0]     r0, r1, fz, dx, dy, xr, cr, sr;
    logic                   fneg;
    logic                   idle_like;

    assign idle_like = (r_st == vmt_pkg::C_IDLE) || (r_st == vmt_pkg::C_DONE);

    always_comb begin
        ang_ext = {{(RED_W-32){i_angle[31]}}, i_angle} << vmt_pkg::SHIFT;
        cmp     = TWO_PI_W << r_j;
        r0      = {1'b0, r_u[34:0]};
        r1      = (r0 > 36'(vmt_pkg::PI_Q30)) ? r0 - 36'(vmt_pkg::TWO_PI_Q30) : r0;
        fneg    = 1'b0;
        fz      = r1;
        if (r1 > 36'(vmt_pkg::HALF_PI_Q30)) begin
            fz   = 36'(vmt_pkg::PI_Q30) - r1;
            fneg = 1'b1;
        end else if (r1 < -36'(vmt_pkg::HALF_PI_Q30)) begin
            fz   = -36'(vmt_pkg::PI_Q30) - r1;
            fneg = 1'b1;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        xr = r_neg ? -r_x : r_x;
        cr = (xr  + (36'sd1 <<< (vmt_pkg::SHIFT - 1))) >>> vmt_pkg::SHIFT;
        sr = (r_y + (36'sd1 <<< (vmt_pkg::SHIFT - 1))) >>> vmt_pkg::SHIFT;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            vmt_pkg::C_IDLE, vmt_pkg::C_DONE: begin
                n_st = i_start ? vmt_pkg::C_RED : vmt_pkg::C_IDLE;
            end
            vmt_pkg::C_RED: begin
                if (r_j == '0) n_st = vmt_pkg::C_FOLD;
            end
            vmt_pkg::C_FOLD: n_st = vmt_pkg::C_ITER;
            vmt_pkg::C_ITER: begin
                if (r_i == vmt_pkg::IT_W'(vmt_pkg::N_IT - 1)) n_st = vmt_pkg::C_DONE;
            end
            default: n_st = vmt_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= vmt_pkg::C_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (idle_like && i_start) begin
            // bias keeps the dividend positive: floor modulo by subtraction
            r_u <= ang_ext + (TWO_PI_W << vmt_pkg::RED_M);
            r_j <= vmt_pkg::J_W'(vmt_pkg::RED_M);
        end
        if (r_st == vmt_pkg::C_RED) begin
            if (r_u >= cmp) r_u <= r_u - cmp;
            r_j <= r_j - 1'b1;
        end
        if (r_st == vmt_pkg::C_FOLD) begin
            r_z   <= fz;
            r_x   <= 36'(vmt_pkg::GAIN_Q30);
            r_y   <= '0;
            r_neg <= fneg;
            r_i   <= '0;
        end
        if (r_st == vmt_pkg::C_ITER) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - vmt_pkg::f_atan(r_i);
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + vmt_pkg::f_atan(r_i);
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_trig.done  = (r_st == vmt_pkg::C_DONE);
    assign o_trig.cos_v = cr[31:0];
    assign o_trig.sin_v = sr[31:0];
endmodule
